// ===== rtl/gtp_pkg.sv =====
`default_nettype none
package gtp_pkg;

   // Codes packed into one output byte
   localparam int CODES_PER_BYTE = 4;
   // Default depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Characters recognized by the decoder
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_ONE  = 8'h31;
   localparam logic [7:0] CHAR_TWO  = 8'h32;
   localparam logic [7:0] CHAR_N    = 8'h4E;

   // Genotype codes
   localparam logic [1:0] CODE_ZERO = 2'd0;
   localparam logic [1:0] CODE_ONE  = 2'd1;
   localparam logic [1:0] CODE_TWO  = 2'd2;
   localparam logic [1:0] CODE_N    = 2'd3;

   // Character classes
   localparam logic [1:0] KIND_DIGIT = 2'd0;
   localparam logic [1:0] KIND_NA    = 2'd1;
   localparam logic [1:0] KIND_BAD   = 2'd2;

   // Characters skipped after a digit (separator) or after N (A, separator)
   localparam logic [1:0] SKIP_DIGIT = 2'd1;
   localparam logic [1:0] SKIP_NA    = 2'd2;

   // One classified character
   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] code;
      logic       eol;
   } item_type;

endpackage
`default_nettype wire

// ===== rtl/gtp_front.sv =====
`default_nettype none
module gtp_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_ch,
   input  wire logic              req_end_of_line,
   output logic                   item_valid,
   input  wire logic              item_ready,
   output gtp_pkg::item_type      item
);

   logic              valid_ff;
   logic              valid_in;
   gtp_pkg::item_type item_ff;
   gtp_pkg::item_type item_in;

   // Accept when the stage is empty or drains this cycle
   assign req_ready = !valid_ff || item_ready;

   // Classify the character
   always_comb begin
      item_in.eol = req_end_of_line;
      unique case (req_ch)
         gtp_pkg::CHAR_ZERO: begin
            item_in.kind = gtp_pkg::KIND_DIGIT;
            item_in.code = gtp_pkg::CODE_ZERO;
         end
         gtp_pkg::CHAR_ONE: begin
            item_in.kind = gtp_pkg::KIND_DIGIT;
            item_in.code = gtp_pkg::CODE_ONE;
         end
         gtp_pkg::CHAR_TWO: begin
            item_in.kind = gtp_pkg::KIND_DIGIT;
            item_in.code = gtp_pkg::CODE_TWO;
         end
         gtp_pkg::CHAR_N: begin
            item_in.kind = gtp_pkg::KIND_NA;
            item_in.code = gtp_pkg::CODE_N;
         end
         default: begin
            item_in.kind = gtp_pkg::KIND_BAD;
            item_in.code = gtp_pkg::CODE_ZERO;
         end
      endcase
   end

   // Hold or advance the stage valid
   always_comb begin
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (item_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload on accept
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

// ===== rtl/gtp_queue.sv =====
`default_nettype none
module gtp_queue #(
   parameter int DEPTH = gtp_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire gtp_pkg::item_type push_item,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output gtp_pkg::item_type      pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   gtp_pkg::item_type entries [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entries[rd_ptr_ff];

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the item
   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/gtp_back.sv =====
`default_nettype none
module gtp_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   output logic                   item_ready,
   input  wire gtp_pkg::item_type item,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_packed_byte,
   output logic                   rsp_bad_char,
   output logic                   rsp_line_done
);

   localparam logic [1:0] LAST_SLOT = 2'(gtp_pkg::CODES_PER_BYTE - 1);

   logic [1:0] skip_ff, skip_in;
   logic [7:0] accum_ff, accum_in;
   logic [1:0] count_ff, count_in;
   logic       failed_ff, failed_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       bad_ff, bad_in;
   logic       done_ff, done_in;

   logic       take;
   logic       has_result;
   logic [7:0] merged;

   // Take an item when the output register is free or drains
   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign take       = item_valid && item_ready;

   // Place the new code at the current slot
   assign merged = accum_ff | ({6'b0, item.code} << {count_ff, 1'b0});

   // Carry out one item
   always_comb begin
      skip_in    = skip_ff;
      accum_in   = accum_ff;
      count_in   = count_ff;
      failed_in  = failed_ff;
      has_result = 1'b0;
      byte_in    = 8'd0;
      bad_in     = 1'b0;
      done_in    = 1'b0;
      priority if (failed_ff) begin
         // Drop characters until the line ends
         if (item.eol) begin
            failed_in = 1'b0;
            skip_in   = 2'd0;
            accum_in  = 8'd0;
            count_in  = 2'd0;
         end
      end else if (skip_ff != 2'd0) begin
         skip_in = skip_ff - 1'b1;
         if (item.eol) begin
            // Flush a partial byte at line end
            if (count_ff != 2'd0) begin
               has_result = 1'b1;
               byte_in    = accum_ff;
               done_in    = 1'b1;
            end
            skip_in  = 2'd0;
            accum_in = 8'd0;
            count_in = 2'd0;
         end
      end else begin
         unique case (item.kind)
            gtp_pkg::KIND_DIGIT, gtp_pkg::KIND_NA: begin
               skip_in = (item.kind == gtp_pkg::KIND_NA) ? gtp_pkg::SKIP_NA
                                                         : gtp_pkg::SKIP_DIGIT;
               if (count_ff == LAST_SLOT || item.eol) begin
                  has_result = 1'b1;
                  byte_in    = merged;
                  done_in    = item.eol;
                  accum_in   = 8'd0;
                  count_in   = 2'd0;
                  if (item.eol) begin
                     skip_in = 2'd0;
                  end
               end else begin
                  accum_in = merged;
                  count_in = count_ff + 1'b1;
               end
            end
            default: begin
               // Abort the line
               has_result = 1'b1;
               bad_in     = 1'b1;
               done_in    = 1'b1;
               skip_in    = 2'd0;
               accum_in   = 8'd0;
               count_in   = 2'd0;
               failed_in  = !item.eol;
            end
         endcase
      end
   end

   // Hold or advance the output register
   always_comb begin
      if (take) begin
         rsp_valid_in = has_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff      <= 2'd0;
         accum_ff     <= 8'd0;
         count_ff     <= 2'd0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            skip_ff   <= skip_in;
            accum_ff  <= accum_in;
            count_ff  <= count_in;
            failed_ff <= failed_in;
         end
      end
   end

   // Load result payload
   always_ff @(posedge clock) begin
      if (take && has_result) begin
         byte_ff <= byte_in;
         bad_ff  <= bad_in;
         done_ff <= done_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_packed_byte = byte_ff;
   assign rsp_bad_char    = bad_ff;
   assign rsp_line_done   = done_ff;

endmodule
`default_nettype wire

// ===== rtl/genotype_char_two_bit_packer.sv =====
// Genotype character packer.
// The req channel carries one ASCII character of a genotype value field per
// item (req_ch) with req_end_of_line marking the last character of a line.
// Characters '0', '1', '2' map to codes 0..2 and 'N' (of "NA") to code 3;
// separators are skipped. Four codes pack into rsp_packed_byte, first code
// in bits 1:0. A byte leaves as soon as it fills, a partial byte at line end.
// Any other character yields one item with rsp_bad_char and rsp_line_done
// set, and the rest of that line is dropped.
// Throughput: one item per cycle on both channels while rsp_ready stays
// high. A result reaches rsp through the front classify register, then the
// queue, then the pack unit's output register.
// Items that produce no result are consumed silently.
// A synchronous active-high reset empties the queue and output register and
// clears all line state. When rsp_ready is low the output register holds
// its item; the queue absorbs up to QUEUE_DEPTH further characters plus one
// in the front register before req_ready drops.
`default_nettype none
module genotype_char_two_bit_packer #(
   parameter int QUEUE_DEPTH = gtp_pkg::QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_ch,
   input  wire logic       req_end_of_line,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_packed_byte,
   output logic            rsp_bad_char,
   output logic            rsp_line_done
);

   logic              front_valid;
   logic              front_ready;
   gtp_pkg::item_type front_item;
   logic              queue_valid;
   logic              queue_ready;
   gtp_pkg::item_type queue_item;

   gtp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_ch          (req_ch),
      .req_end_of_line (req_end_of_line),
      .item_valid      (front_valid),
      .item_ready      (front_ready),
      .item            (front_item)
   );

   gtp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_item   (queue_item)
   );

   gtp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (queue_valid),
      .item_ready      (queue_ready),
      .item            (queue_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_packed_byte (rsp_packed_byte),
      .rsp_bad_char    (rsp_bad_char),
      .rsp_line_done   (rsp_line_done)
   );

endmodule
`default_nettype wire
